// ----- rtl/s2a_pkg.sv -----
// shared types, constants and the set 1 key table for the scan code to ascii queue
// no dependencies
package s2a_pkg;

  localparam int unsigned FifoDepthDefault = 256;
  localparam int unsigned CodeW            = 8;
  localparam int unsigned CharW            = 7;

  localparam logic [CodeW-1:0] ReleaseBit = 8'h80;
  localparam logic [CodeW-1:0] MapSize    = 8'd58;

  typedef logic [CodeW-1:0] code_t;
  typedef logic [CharW-1:0] char_t;

  typedef enum logic {
    MODE_SCAN = 1'b0,
    MODE_READ = 1'b1
  } mode_e;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  typedef struct packed {
    logic  we;
    logic  re;
    char_t wdata;
  } ram_req_t;

  function automatic char_t key_map(input code_t code);
    char_t ch;
    ch = '0;
    if (((code & ReleaseBit) == '0) && (code < MapSize)) begin
      case (code)
        8'd2:  ch = 7'h31;
        8'd3:  ch = 7'h32;
        8'd4:  ch = 7'h33;
        8'd5:  ch = 7'h34;
        8'd6:  ch = 7'h35;
        8'd7:  ch = 7'h36;
        8'd8:  ch = 7'h37;
        8'd9:  ch = 7'h38;
        8'd10: ch = 7'h39;
        8'd11: ch = 7'h30;
        8'd12: ch = 7'h2d;
        8'd13: ch = 7'h3d;
        8'd14: ch = 7'h08;
        8'd15: ch = 7'h09;
        8'd16: ch = 7'h71;
        8'd17: ch = 7'h77;
        8'd18: ch = 7'h65;
        8'd19: ch = 7'h72;
        8'd20: ch = 7'h74;
        8'd21: ch = 7'h79;
        8'd22: ch = 7'h75;
        8'd23: ch = 7'h69;
        8'd24: ch = 7'h6f;
        8'd25: ch = 7'h70;
        8'd26: ch = 7'h5b;
        8'd27: ch = 7'h5d;
        8'd28: ch = 7'h0a;
        8'd30: ch = 7'h61;
        8'd31: ch = 7'h73;
        8'd32: ch = 7'h64;
        8'd33: ch = 7'h66;
        8'd34: ch = 7'h67;
        8'd35: ch = 7'h68;
        8'd36: ch = 7'h6a;
        8'd37: ch = 7'h6b;
        8'd38: ch = 7'h6c;
        8'd39: ch = 7'h3b;
        8'd40: ch = 7'h27;
        8'd41: ch = 7'h60;
        8'd43: ch = 7'h5c;
        8'd44: ch = 7'h7a;
        8'd45: ch = 7'h78;
        8'd46: ch = 7'h63;
        8'd47: ch = 7'h76;
        8'd48: ch = 7'h62;
        8'd49: ch = 7'h6e;
        8'd50: ch = 7'h6d;
        8'd51: ch = 7'h2c;
        8'd52: ch = 7'h2e;
        8'd53: ch = 7'h2f;
        8'd55: ch = 7'h2a;
        8'd57: ch = 7'h20;
        default: ch = '0;
      endcase
    end
    return ch;
  endfunction

endpackage

// ----- rtl/s2a_if.sv -----
// valid/ready channel interfaces for input words and result words
// depends on s2a_pkg
interface s2a_in_if;
  logic             valid;
  logic             ready;
  logic             mode;
  s2a_pkg::code_t   scan_code;

  modport source (output valid, output mode, output scan_code, input ready);
  modport sink   (input valid, input mode, input scan_code, output ready);
endinterface

interface s2a_out_if;
  logic             valid;
  logic             ready;
  s2a_pkg::char_t   read_char;
  logic             char_valid;
  logic             chars_available;

  modport source (output valid, output read_char, output char_valid,
                  output chars_available, input ready);
  modport sink   (input valid, input read_char, input char_valid,
                  input chars_available, output ready);
endinterface

// ----- rtl/scancode_to_ascii_fifo.sv -----
// top level of the scan code to ascii character queue
// depends on s2a_pkg, s2a_if, s2a_char_ram, s2a_ctrl
//
//   channel  dir  fields                                   accepted when
//   in_i     in   mode, scan_code                          valid && ready
//   out_o    out  read_char, char_valid, chars_available   valid && ready
//
// a scan code word or a read of an empty queue loads the result register directly; a
// read that pops a character passes through ST_READ, as the store's read data is registered
// reset clears pointers, fill count and the result valid flag; no clearing pass
// the store itself has no reset, only written entries are ever read
// a new word is taken while the result register is empty or being drained
// and no popped character is being fetched from the store
module scancode_to_ascii_fifo #(
  parameter int unsigned FIFO_DEPTH = s2a_pkg::FifoDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  s2a_in_if.sink    in_i,
  s2a_out_if.source out_o
);
  import s2a_pkg::*;

  localparam int unsigned AW = $clog2(FIFO_DEPTH);

  ram_req_t      ram_req;
  logic [AW-1:0] waddr, raddr;
  char_t         rdata;

  s2a_ctrl #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .out_o     (out_o),
    .ram_req_o (ram_req),
    .waddr_o   (waddr),
    .raddr_o   (raddr),
    .rdata_i   (rdata)
  );

  s2a_char_ram #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .waddr_i (waddr),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule

// ----- rtl/s2a_char_ram.sv -----
// character store: one write port, one read port, registered read data
// depends on s2a_pkg
module s2a_char_ram #(
  parameter int unsigned FIFO_DEPTH = s2a_pkg::FifoDepthDefault,
  parameter int unsigned AW         = $clog2(FIFO_DEPTH)
) (
  input  logic              clk_i,
  input  s2a_pkg::ram_req_t req_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [AW-1:0]     raddr_i,
  output s2a_pkg::char_t    rdata_o
);
  import s2a_pkg::*;

  char_t mem_q [FIFO_DEPTH];
  char_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[waddr_i] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/s2a_ctrl.sv -----
// queue control: key lookup, pointers, fill count, read sequencing, result register
// depends on s2a_pkg and s2a_if
module s2a_ctrl #(
  parameter int unsigned FIFO_DEPTH = s2a_pkg::FifoDepthDefault,
  parameter int unsigned AW         = $clog2(FIFO_DEPTH),
  parameter int unsigned CW         = $clog2(FIFO_DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  s2a_in_if.sink            in_i,
  s2a_out_if.source         out_o,
  output s2a_pkg::ram_req_t ram_req_o,
  output logic [AW-1:0]     waddr_o,
  output logic [AW-1:0]     raddr_o,
  input  s2a_pkg::char_t    rdata_i
);
  import s2a_pkg::*;

  localparam logic [AW-1:0] LastIdx = AW'(FIFO_DEPTH - 1);
  localparam logic [CW-1:0] Full    = CW'(FIFO_DEPTH);

  state_e        state_q, state_d;
  logic [AW-1:0] wptr_q, wptr_d;
  logic [AW-1:0] rptr_q, rptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          ovalid_q, ovalid_d;
  char_t         ochar_q, ochar_d;
  logic          ocv_q, ocv_d;
  logic          oavail_q, oavail_d;

  logic  out_free, accept, push, pop;
  char_t mapped;

  assign out_free = !ovalid_q || out_o.ready;
  assign mapped   = key_map(in_i.scan_code);

  always_comb begin
    state_d  = state_q;
    wptr_d   = wptr_q;
    rptr_d   = rptr_q;
    count_d  = count_q;
    ovalid_d = ovalid_q && !out_o.ready;
    ochar_d  = ochar_q;
    ocv_d    = ocv_q;
    oavail_d = oavail_q;
    in_i.ready = 1'b0;
    accept   = 1'b0;
    push     = 1'b0;
    pop      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_i.ready = out_free;
        accept = in_i.valid && out_free;
        push = accept && (in_i.mode == MODE_SCAN) && (mapped != '0) && (count_q != Full);
        pop  = accept && (in_i.mode == MODE_READ) && (count_q != '0);
        if (push) begin
          wptr_d  = (wptr_q == LastIdx) ? '0 : wptr_q + 1'b1;
          count_d = count_q + 1'b1;
        end
        if (pop) begin
          rptr_d  = (rptr_q == LastIdx) ? '0 : rptr_q + 1'b1;
          count_d = count_q - 1'b1;
          state_d = ST_READ;
        end else if (accept) begin
          ovalid_d = 1'b1;
          ochar_d  = '0;
          ocv_d    = 1'b0;
          oavail_d = (count_d != '0);
        end
      end
      ST_READ: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          ochar_d  = rdata_i;
          ocv_d    = 1'b1;
          oavail_d = (count_q != '0);
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      wptr_q   <= '0;
      rptr_q   <= '0;
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      wptr_q   <= wptr_d;
      rptr_q   <= rptr_d;
      count_q  <= count_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ochar_q  <= ochar_d;
    ocv_q    <= ocv_d;
    oavail_q <= oavail_d;
  end

  assign ram_req_o.we    = push;
  assign ram_req_o.re    = pop;
  assign ram_req_o.wdata = mapped;
  assign waddr_o         = wptr_q;
  assign raddr_o         = rptr_q;

  assign out_o.valid           = ovalid_q;
  assign out_o.read_char       = ochar_q;
  assign out_o.char_valid      = ocv_q;
  assign out_o.chars_available = oavail_q;

endmodule
